/* sv/twwm_pkg.sv */
// Package for the two-voice wavetable mixer: field widths, codes, reset values
// and the sample mixing function.
// Depends on nothing; every other file of the block imports it.
package twwm_pkg;

	localparam int STEP_W    = 26;
	localparam int INDEX_W   = 10;
	localparam int SAMPLE_W  = 16;
	localparam int DAC_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_VOICE_ONE_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOICE_TWO_STEP = 2'd1;

	localparam logic [STEP_W-1:0] STEP_ONE_RST = 26'd363308;
	localparam logic [STEP_W-1:0] STEP_TWO_RST = 26'd457740;

	localparam int MIX_SHIFT = 5;
	localparam int DAC_MID   = 2048;
	localparam int DAC_MAX   = 4095;

	// Number of conditional-subtract stages that bring a step below the
	// phase limit, given the phase width.
	function automatic int red_stages(input int ph_w);
		int n;
		n = STEP_W - ph_w + 1;
		return (n < 1) ? 1 : n;
	endfunction

	// Sum two samples, divide by 32 rounding toward zero, offset and clip.
	function automatic logic [DAC_W-1:0] mix_code(input logic signed [SAMPLE_W-1:0] a,
	                                              input logic signed [SAMPLE_W-1:0] b);
		logic signed [SAMPLE_W:0]   sum;
		logic signed [SAMPLE_W:0]   biased;
		logic signed [SAMPLE_W:0]   quot;
		logic signed [SAMPLE_W+1:0] code;
		sum    = (SAMPLE_W+1)'(a) + (SAMPLE_W+1)'(b);
		biased = sum + (sum[SAMPLE_W] ? (SAMPLE_W+1)'((1 << MIX_SHIFT) - 1)
		                              : (SAMPLE_W+1)'(0));
		quot   = biased >>> MIX_SHIFT;
		code   = (SAMPLE_W+2)'(quot) + (SAMPLE_W+2)'(DAC_MID);
		if (code > (SAMPLE_W+2)'(DAC_MAX)) begin
			return DAC_W'(DAC_MAX);
		end else if (code < (SAMPLE_W+2)'(0)) begin
			return '0;
		end
		return code[DAC_W-1:0];
	endfunction

endpackage

/* sv/twwm_ifs.sv */
// Channel interfaces of the wavetable mixer: item input and DAC result output.
// Depends on twwm_pkg for the field widths.
interface twwm_item_if;
	import twwm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [INDEX_W-1:0]         table_index;
	logic signed [SAMPLE_W-1:0] table_value;
	modport source(output valid, cmd, table_index, table_value, input ready);
	modport sink(input valid, cmd, table_index, table_value, output ready);
endinterface

interface twwm_result_if;
	import twwm_pkg::*;
	logic             valid;
	logic             ready;
	logic [DAC_W-1:0] dac_code;
	modport source(output valid, dac_code, input ready);
	modport sink(input valid, dac_code, output ready);
endinterface

/* sv/twwm_step_red.sv */
// Step reduction pipeline: brings a 26-bit phase step below the phase limit.
// Depends on twwm_pkg; one conditional subtract of a shifted limit per stage.
module twwm_step_red #(
	parameter int TABLE_DEPTH   = 1000,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                                  clk,
	input  logic [twwm_pkg::STEP_W-1:0]                           step,
	output logic [$clog2(TABLE_DEPTH)+FRACTION_BITS-1:0]          step_mod
);
	import twwm_pkg::*;

	localparam int PH_W  = $clog2(TABLE_DEPTH) + FRACTION_BITS;
	localparam int RED_N = red_stages(PH_W);
	localparam int RW    = ((STEP_W > PH_W) ? STEP_W : PH_W) + 1;

	logic [RW-1:0] stage_q [RED_N];

	for (genvar j = 0; j < RED_N; j++) begin : g_stage
		localparam int K = RED_N - 1 - j;
		localparam logic [RW-1:0] SUB = RW'(TABLE_DEPTH) << (FRACTION_BITS + K);
		logic [RW-1:0] prev;
		if (j == 0) begin : g_first
			assign prev = RW'(step);
		end else begin : g_next
			assign prev = stage_q[j-1];
		end
		always_ff @(posedge clk) begin
			stage_q[j] <= (prev >= SUB) ? prev - SUB : prev;
		end
	end

	assign step_mod = PH_W'(stage_q[RED_N-1]);

endmodule

/* sv/two_voice_wavetable_mixer_unit.sv */
// Top level of the two-voice wavetable mixer: step registers, phase accumulators,
// the wave table memory and the mix/output stages.
// Depends on twwm_pkg, twwm_ifs and twwm_step_red.
//
// Channel   Dir  Handshake        Payload
// item      in   valid/ready      cmd, table_index, table_value
// result    out  valid/ready      dac_code
// cfg       in   cfg_we only      cfg_index, cfg_data
//
// One item is taken per cycle while item.ready is high. A table write completes
// in the accepting cycle and gives no transaction on result. A tick advances
// both phases in the accepting cycle and reads both samples through the two read
// ports of the table memory into the memory read stage; its DAC code is then
// loaded into the output register, which offers the result transaction. After
// reset and after each configuration write, item.ready stays low while the step
// reduction pipeline settles. A stalled result holds in the output register;
// one further tick may still be taken and waits in the memory read stage.
module two_voice_wavetable_mixer_unit #(
	parameter int TABLE_DEPTH   = 1000,
	parameter int FRACTION_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	twwm_item_if.sink                          item,
	twwm_result_if.source                      result,
	input  logic                               cfg_we,
	input  logic [twwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [twwm_pkg::STEP_W-1:0]        cfg_data
);
	import twwm_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int PH_W  = IDX_W + FRACTION_BITS;
	localparam int RED_N = red_stages(PH_W);
	localparam int SET_W = $clog2(RED_N + 1);
	// Phase limit: table length in 11.16 fixed point at the default parameters.
	localparam logic [PH_W:0] PHASE_LIM = (PH_W+1)'(TABLE_DEPTH) << FRACTION_BITS;

	// Step registers; write them only while the block is idle (not enforced here).
	logic [STEP_W-1:0] step_one_q;
	logic [STEP_W-1:0] step_two_q;
	logic [SET_W-1:0]  settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_one_q <= STEP_ONE_RST;
			step_two_q <= STEP_TWO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VOICE_ONE_STEP: step_one_q <= cfg_data;
				REG_VOICE_TWO_STEP: step_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off items until the reduced steps reflect the current registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SET_W'(RED_N);
		end else if (cfg_we) begin
			settle_q <= SET_W'(RED_N);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SET_W'(1);
		end
	end

	// Reduce each step modulo the phase limit so one subtract wraps the phase.
	logic [PH_W-1:0] step_one_mod;
	logic [PH_W-1:0] step_two_mod;

	twwm_step_red #(.TABLE_DEPTH(TABLE_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_red_one (
		.clk      (clk),
		.step     (step_one_q),
		.step_mod (step_one_mod)
	);

	twwm_step_red #(.TABLE_DEPTH(TABLE_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_red_two (
		.clk      (clk),
		.step     (step_two_q),
		.step_mod (step_two_mod)
	);

	// Handshake and pipeline control.
	logic valid_s1;
	logic out_valid_q;
	logic s1_adv;
	logic item_acc;
	logic tick_acc;
	logic wr_acc;

	assign s1_adv     = !out_valid_q || result.ready;
	assign item.ready = (settle_q == '0) && (!valid_s1 || s1_adv);
	assign item_acc   = item.valid && item.ready;
	assign tick_acc   = item_acc && (item.cmd == CMD_TICK);
	// Drop writes that fall outside the table.
	assign wr_acc     = item_acc && (item.cmd == CMD_WRITE)
	                    && (32'(item.table_index) < 32'(TABLE_DEPTH));

	// Phase accumulators: add the reduced step, wrap once at the limit.
	logic [PH_W-1:0] phase_one_q;
	logic [PH_W-1:0] phase_two_q;
	logic [PH_W:0]   sum_one;
	logic [PH_W:0]   sum_two;
	logic [PH_W-1:0] phase_one_nx;
	logic [PH_W-1:0] phase_two_nx;

	always_comb begin
		sum_one      = (PH_W+1)'(phase_one_q) + (PH_W+1)'(step_one_mod);
		sum_two      = (PH_W+1)'(phase_two_q) + (PH_W+1)'(step_two_mod);
		phase_one_nx = PH_W'((sum_one >= PHASE_LIM) ? sum_one - PHASE_LIM : sum_one);
		phase_two_nx = PH_W'((sum_two >= PHASE_LIM) ? sum_two - PHASE_LIM : sum_two);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_one_q <= '0;
			phase_two_q <= '0;
		end else if (tick_acc) begin
			phase_one_q <= phase_one_nx;
			phase_two_q <= phase_two_nx;
		end
	end

	// Wave table: one write port, two registered read ports addressed by the
	// integer parts of the advanced phases. A write and a tick never share a
	// cycle, so a tick always sees every earlier write.
	logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
	logic signed [SAMPLE_W-1:0] samp_one_s1;
	logic signed [SAMPLE_W-1:0] samp_two_s1;
	logic [IDX_W-1:0]           wr_addr;
	logic [IDX_W-1:0]           rd_one;
	logic [IDX_W-1:0]           rd_two;

	assign wr_addr = IDX_W'(item.table_index);
	assign rd_one  = phase_one_nx[PH_W-1:FRACTION_BITS];
	assign rd_two  = phase_two_nx[PH_W-1:FRACTION_BITS];

	always_ff @(posedge clk) begin
		if (wr_acc) begin
			wave_mem[wr_addr] <= item.table_value;
		end
		if (tick_acc) begin
			samp_one_s1 <= wave_mem[rd_one];
			samp_two_s1 <= wave_mem[rd_two];
		end
	end

	// Stage 1 valid: a tick's samples wait here until the output register frees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output register: mix, offset and clip into the DAC code.
	logic [DAC_W-1:0] dac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			dac_q <= mix_code(samp_one_s1, samp_two_s1);
		end
	end

	assign result.valid    = out_valid_q;
	assign result.dac_code = dac_q;

endmodule

/* sv/twwm_checker.sv */
// Port-level checker for the wavetable mixer, bound to the top level.
// Depends on twwm_pkg and two_voice_wavetable_mixer_unit.
module twwm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          item_cmd,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [twwm_pkg::DAC_W-1:0]    result_dac_code,
	input logic                          cfg_we
);
	import twwm_pkg::*;

	// A stalled result stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its code.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_dac_code))
		else $error("result code changed while stalled");

	// A configuration write holds off items while the steps settle.
	a_cfg_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !item_ready)
		else $error("item taken straight after a configuration write");

	// A tick taken while the sink stays ready reaches the result channel.
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_cmd == CMD_TICK && result_ready)
		##1 result_ready |=> result_valid)
		else $error("tick result missing");

endmodule

bind two_voice_wavetable_mixer_unit twwm_checker u_twwm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.item_cmd        (item.cmd),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_dac_code (result.dac_code),
	.cfg_we          (cfg_we)
);
